[hw/rtl/sroc_pkg.sv]
// Shared types and constants for the segment raster overlap counter.
package sroc_pkg;

  // Fixed field widths
  localparam int CoordW = 10;
  localparam int TallyW = 21;
  localparam int CovW   = 2;

  // Default grid side
  localparam int GridSideDefault = 1024;

  // Saturation limit of the overlap tally
  localparam logic [TallyW-1:0] TallyMax = '1;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_RESULT
  } sroc_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_en;  // write zero to the next cell of the clearing pass
    logic load;      // take the segment beat and set up the walk
    logic step;      // visit the current point and advance
    logic capture;   // copy the tally into the output register
  } sroc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_done;  // clearing pass is at its last cell
    logic walk_last;   // current point is the last of the segment
  } sroc_sts_t;

endpackage

[hw/rtl/sroc_ctrl.sv]
// Controller state machine for the segment raster overlap counter.
module sroc_ctrl
  import sroc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  sroc_sts_t sts_i,
  output sroc_cmd_t cmd_o
);

  sroc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // The output register can take a new beat when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // The last cell's write and tally update land at the end of this cycle.
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/sroc_dpath.sv]
// Datapath: segment walker, coverage memory, overlap tally and output register.
module sroc_dpath
  import sroc_pkg::*;
#(
  parameter int GRID_SIDE = GridSideDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sroc_cmd_t         cmd_i,
  output sroc_sts_t         sts_o,
  input  logic [CoordW-1:0] x_start_i,
  input  logic [CoordW-1:0] y_start_i,
  input  logic [CoordW-1:0] x_end_i,
  input  logic [CoordW-1:0] y_end_i,
  output logic [TallyW-1:0] overlap_total_o
);

  localparam int GridIdxW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int Depth    = GRID_SIDE * GRID_SIDE;
  localparam int AddrW    = $clog2(Depth);
  localparam int PosW     = (CoordW + 2 > GridIdxW + 2) ? CoordW + 2 : GridIdxW + 2;

  localparam logic signed [PosW-1:0] SideS    = PosW'(GRID_SIDE);
  localparam logic signed [1:0]      StepPos  = 2'sb01;
  localparam logic signed [1:0]      StepNeg  = 2'sb11;
  localparam logic signed [1:0]      StepNone = 2'sb00;

  localparam logic [CovW-1:0] CovNone  = CovW'(0);
  localparam logic [CovW-1:0] CovOnce  = CovW'(1);
  localparam logic [CovW-1:0] CovMulti = CovW'(2);

  // Coverage store
  logic [CovW-1:0] mem [Depth];

  logic signed [PosW-1:0] x_q, y_q;
  logic signed [1:0]      dx_q, dy_q;
  logic [CoordW-1:0]      rem_q;
  logic [AddrW-1:0]       clr_q;
  logic                   wr_q;
  logic [AddrW-1:0]       wr_addr_q;
  logic [CovW-1:0]        rd_data_q;
  logic [TallyW-1:0]      tally_q;
  logic [TallyW-1:0]      out_total_q;

  // Segment set-up from the input beat
  logic                   vert, horiz;
  logic [CoordW-1:0]      x_lo, x_hi, y_lo, y_hi;
  logic [CoordW-1:0]      sx, sy, cnt;
  logic signed [1:0]      sdx, sdy;

  always_comb begin
    vert  = (x_start_i == x_end_i);
    horiz = !vert && (y_start_i == y_end_i);
    x_lo  = (x_start_i < x_end_i) ? x_start_i : x_end_i;
    x_hi  = (x_start_i < x_end_i) ? x_end_i : x_start_i;
    y_lo  = (y_start_i < y_end_i) ? y_start_i : y_end_i;
    y_hi  = (y_start_i < y_end_i) ? y_end_i : y_start_i;
    cnt   = vert ? (y_hi - y_lo) : (x_hi - x_lo);
    if (vert) begin
      sx  = x_start_i;
      sy  = y_lo;
      sdx = StepNone;
      sdy = StepPos;
    end else if (horiz) begin
      sx  = x_lo;
      sy  = y_start_i;
      sdx = StepPos;
      sdy = StepNone;
    end else begin
      sx  = x_start_i;
      sy  = y_start_i;
      sdx = (x_start_i > x_end_i) ? StepNeg : StepPos;
      sdy = (y_start_i > y_end_i) ? StepNeg : StepPos;
    end
  end

  // Walker registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= PosW'(sx);
      y_q   <= PosW'(sy);
      dx_q  <= sdx;
      dy_q  <= sdy;
      rem_q <= cnt;
    end else if (cmd_i.step) begin
      x_q   <= x_q + PosW'(dx_q);
      y_q   <= y_q + PosW'(dy_q);
      rem_q <= rem_q - CoordW'(1);
    end
  end

  // Current point: grid check and cell address
  logic             in_grid;
  logic [AddrW-1:0] rd_addr;

  assign in_grid = !x_q[PosW-1] && (x_q < SideS) && !y_q[PosW-1] && (y_q < SideS);
  assign rd_addr = AddrW'(y_q[GridIdxW-1:0]) * AddrW'(GRID_SIDE)
                 + AddrW'(x_q[GridIdxW-1:0]);

  // Clearing pass counter and pending write flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      wr_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_q <= clr_q + AddrW'(1);
      end
      wr_q <= cmd_i.step && in_grid;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= rd_addr;
  end

  // Saturating coverage update
  logic [CovW-1:0] new_cov;
  always_comb begin
    case (rd_data_q)
      CovNone: new_cov = CovOnce;
      default: new_cov = CovMulti;
    endcase
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      mem[clr_q] <= CovNone;
    end else if (wr_q) begin
      mem[wr_addr_q] <= new_cov;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Overlap tally: counts each cell's first move from one to two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
    end else if (wr_q && (rd_data_q == CovOnce) && (tally_q != TallyMax)) begin
      tally_q <= tally_q + TallyW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      out_total_q <= tally_q;
    end
  end

  assign overlap_total_o  = out_total_q;
  assign sts_o.clear_done = (clr_q == AddrW'(Depth - 1));
  assign sts_o.walk_last  = (rem_q == '0);

endmodule

[hw/rtl/segment_raster_overlap_counter_top.sv]
// Segment raster overlap counter: top level joining controller and datapath.
//
// Input channel: one beat is one line segment (x_start, y_start, x_end, y_end),
// taken when in_valid_i is high and in_stall_o is low. Output channel: one beat
// per segment carrying overlap_total, the number of grid cells covered by two
// or more segments so far, taken when out_valid_o is high and out_stall_i low.
// The segment is walked one grid point a cycle through a read-modify-write of
// the 2-bit coverage memory; one read-modify-write a cycle sets this pace. A
// segment of P points (P = segment length + 1) is walked in full and its result
// captured before the next segment is accepted.
// Horizontal, vertical and diagonal segments are all walked one point a cycle.
// After the last point come ST_FLUSH, then ST_RESULT, which captures the result.
// After reset the coverage memory is cleared one cell a cycle, all
// GRID_SIDE * GRID_SIDE cells; in_stall_o stays high until this is done.
// A result that waits on out_stall_i does not block the next segment: it is
// accepted and walked, and its own result waits until the output register
// has been taken.
module segment_raster_overlap_counter_top
  import sroc_pkg::*;
#(
  parameter int GRID_SIDE = GridSideDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] x_start_i,
  input  logic [CoordW-1:0] y_start_i,
  input  logic [CoordW-1:0] x_end_i,
  input  logic [CoordW-1:0] y_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TallyW-1:0] overlap_total_o
);

  sroc_cmd_t cmd;
  sroc_sts_t sts;

  // Controller
  sroc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath
  sroc_dpath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .x_start_i       (x_start_i),
    .y_start_i       (y_start_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .overlap_total_o (overlap_total_o)
  );

  // A new result never overwrites one still held by the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> !(out_valid_o && out_stall_i))
    else $error("result captured over a stalled output beat");

  // No segment is taken while a walk is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> in_stall_o)
    else $error("input accepted during a walk");

  // The clearing pass never overlaps segment work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_en |-> !(cmd.step || cmd.load || cmd.capture))
    else $error("clearing pass overlaps segment work");

  // A captured result is presented on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> out_valid_o)
    else $error("captured result not presented");

endmodule
